>>> hdl/jsu8_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// jsu8_pkg: shared types, constants and helpers of the JSON string decoder
// Parse modes, result kinds, error codes, the result group that travels from
// the front end to the back end, and the encoding helpers.
// ---------------------------------------------------------------------------
package jsu8_pkg;

	// Parse modes of the front end
	typedef enum logic [3:0] {
		MODE_IDLE,
		MODE_BODY,
		MODE_UTF8,
		MODE_ESC,
		MODE_HEX,
		MODE_LOW_BS,
		MODE_LOW_U,
		MODE_LOW_HEX
	} mode_t;

	// Kinds of result
	typedef enum logic [1:0] {
		KIND_BYTE  = 2'd0,
		KIND_CLOSE = 2'd1,
		KIND_ERROR = 2'd2
	} kind_t;

	// Error codes
	typedef enum logic [3:0] {
		ERR_NO_QUOTE      = 4'd0,
		ERR_UNTERMINATED  = 4'd1,
		ERR_CONTROL       = 4'd2,
		ERR_BAD_UTF8      = 4'd3,
		ERR_BAD_HEX       = 4'd4,
		ERR_UNPAIRED_HIGH = 4'd5,
		ERR_BAD_LOW       = 4'd6,
		ERR_LONE_LOW      = 4'd7,
		ERR_NUL_ESCAPE    = 4'd8,
		ERR_BAD_ESCAPE    = 4'd9
	} err_t;

	localparam logic [3:0] CODE_NONE = 4'd0;

	// Group sizing
	localparam int MAX_RESULTS     = 4;
	localparam int RES_IDX_W       = $clog2(MAX_RESULTS);
	localparam int RES_CNT_W       = $clog2(MAX_RESULTS + 1);
	localparam int QUEUE_DEPTH_DEF = 4;

	// Port widths
	localparam int IN_TDATA_W  = 8;
	localparam int OUT_TDATA_W = 16;
	localparam int OUT_TUSER_W = 2;

	// Characters and byte bounds
	localparam logic [7:0] CH_NUL    = 8'h00;
	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_SLASH  = 8'h2F;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_B      = 8'h62;
	localparam logic [7:0] CH_F      = 8'h66;
	localparam logic [7:0] CH_N      = 8'h6E;
	localparam logic [7:0] CH_R      = 8'h72;
	localparam logic [7:0] CH_T      = 8'h74;
	localparam logic [7:0] CH_U      = 8'h75;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] ASCII_END = 8'h80;
	localparam logic [7:0] LEAD_MIN  = 8'hC2;
	localparam logic [7:0] LEAD_MAX  = 8'hF4;
	localparam logic [7:0] LEAD_3    = 8'hE0;
	localparam logic [7:0] LEAD_ED   = 8'hED;
	localparam logic [7:0] LEAD_4    = 8'hF0;
	localparam logic [7:0] CONT_MIN  = 8'h80;
	localparam logic [7:0] CONT_MAX  = 8'hBF;

	// Surrogate prefixes (top six bits of a 16-bit code unit)
	localparam logic [5:0] SURR_HIGH = 6'b110110;
	localparam logic [5:0] SURR_LOW  = 6'b110111;
	// 0x10000 expressed in units of 0x400
	localparam logic [10:0] PLANE_BASE = 11'h040;

	typedef struct packed {
		kind_t      kind;
		logic [7:0] data;
		logic [3:0] code;
	} result_t;

	typedef struct packed {
		logic [RES_CNT_W-1:0]           cnt;
		result_t [MAX_RESULTS-1:0]      res;
	} group_t;

	typedef struct packed {
		logic empty;
		logic full;
	} q_status_t;

	// Hex digit value; bit 4 set means not a hex digit
	function automatic logic [4:0] hex_nibble(input logic [7:0] c);
		logic [4:0] v;
		v = 5'h10;
		if (c inside {[8'h30:8'h39]}) v = {1'b0, c[3:0]};
		else if (c inside {[8'h61:8'h66], [8'h41:8'h46]}) v = {1'b0, c[3:0] + 4'd9};
		return v;
	endfunction

	// Simple escape value; bit 8 set when the escape is a simple one
	function automatic logic [8:0] esc_value(input logic [7:0] c);
		logic [8:0] v;
		v = '0;
		case (c)
			CH_QUOTE, CH_BSLASH, CH_SLASH: v = {1'b1, c};
			CH_B:    v = {1'b1, 8'h08};
			CH_F:    v = {1'b1, 8'h0C};
			CH_N:    v = {1'b1, 8'h0A};
			CH_R:    v = {1'b1, 8'h0D};
			CH_T:    v = {1'b1, 8'h09};
			default: v = '0;
		endcase
		return v;
	endfunction

	// Append one result to a group
	function automatic group_t grp_put(input group_t g, input kind_t kind,
			input logic [7:0] data, input logic [3:0] code);
		group_t r;
		r = g;
		r.res[g.cnt[RES_IDX_W-1:0]].kind = kind;
		r.res[g.cnt[RES_IDX_W-1:0]].data = data;
		r.res[g.cnt[RES_IDX_W-1:0]].code = code;
		r.cnt = g.cnt + RES_CNT_W'(1);
		return r;
	endfunction

	// Append a code point as UTF-8
	function automatic group_t grp_cp(input group_t g, input logic [20:0] cp);
		group_t r;
		r = g;
		if (cp <= 21'h7F) begin
			r = grp_put(r, KIND_BYTE, {1'b0, cp[6:0]}, CODE_NONE);
		end else if (cp <= 21'h7FF) begin
			r = grp_put(r, KIND_BYTE, {3'b110, cp[10:6]}, CODE_NONE);
			r = grp_put(r, KIND_BYTE, {2'b10, cp[5:0]}, CODE_NONE);
		end else if (cp <= 21'hFFFF) begin
			r = grp_put(r, KIND_BYTE, {4'b1110, cp[15:12]}, CODE_NONE);
			r = grp_put(r, KIND_BYTE, {2'b10, cp[11:6]}, CODE_NONE);
			r = grp_put(r, KIND_BYTE, {2'b10, cp[5:0]}, CODE_NONE);
		end else begin
			r = grp_put(r, KIND_BYTE, {5'b11110, cp[20:18]}, CODE_NONE);
			r = grp_put(r, KIND_BYTE, {2'b10, cp[17:12]}, CODE_NONE);
			r = grp_put(r, KIND_BYTE, {2'b10, cp[11:6]}, CODE_NONE);
			r = grp_put(r, KIND_BYTE, {2'b10, cp[5:0]}, CODE_NONE);
		end
		return r;
	endfunction

endpackage
`default_nettype wire

>>> hdl/json_string_utf8_decoder_core.sv
`default_nettype none
// With the queue empty, a byte's first result passes through the group queue and then
// the registered output stage before it is on the output.
// Throughput: one byte accepted per cycle while the group queue has room; one result
// delivered per cycle while m_axis_tready is high.
// The group queue (QUEUE_DEPTH groups) absorbs bursts of up to four results per byte.
// Reset (arst_n low) puts the parser in idle, empties the queue and clears tvalid.
// ---------------------------------------------------------------------------
// json_string_utf8_decoder_core: JSON string unescape and UTF-8 check
// Front end parses quoted-string bytes into result groups, a queue decouples
// it from the back end, which streams the results out one per transaction.
// ---------------------------------------------------------------------------
module json_string_utf8_decoder_core
	import jsu8_pkg::*;
#(
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   s_axis_tvalid,
	output logic                        s_axis_tready,
	input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,  // [7:0] data_byte
	input  wire logic                   s_axis_tuser,  // [0] first_byte
	output logic                        m_axis_tvalid,
	input  wire logic                   m_axis_tready,
	output logic [OUT_TDATA_W-1:0]      m_axis_tdata,  // [7:0] out_byte, [11:8] error_code
	output logic [OUT_TUSER_W-1:0]      m_axis_tuser,  // [1:0] result_kind
	output logic                        m_axis_tlast   // last_of_run
);

	logic      accept;
	logic      push;
	logic      pop;
	group_t    front_grp;
	group_t    head_grp;
	q_status_t q_stat;

	// Take bytes while the queue has room
	assign s_axis_tready = !q_stat.full;
	assign accept        = s_axis_tvalid && s_axis_tready;

	jsu8_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.data_byte  (s_axis_tdata),
		.first_byte (s_axis_tuser),
		.push       (push),
		.grp        (front_grp)
	);

	jsu8_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_grp (front_grp),
		.pop      (pop),
		.head_grp (head_grp),
		.status   (q_stat)
	);

	jsu8_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.head_grp      (head_grp),
		.q_stat        (q_stat),
		.pop           (pop),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	// A closed string always ends its run
	a_close_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (m_axis_tuser == KIND_CLOSE) |-> m_axis_tlast)
		else $error("close result without tlast");

	// Queued work reaches an empty output stage in the next cycle
	a_backlog_drains: assert property (@(posedge clk) disable iff (!arst_n)
		!q_stat.empty && !m_axis_tvalid |=> m_axis_tvalid)
		else $error("back end idle with groups queued");

	// Error results carry a defined error code
	a_error_code_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (m_axis_tuser == KIND_ERROR) |->
		m_axis_tdata[11:8] <= ERR_BAD_ESCAPE)
		else $error("error code out of range");

endmodule
`default_nettype wire

>>> hdl/jsu8_front.sv
`default_nettype none
// ---------------------------------------------------------------------------
// jsu8_front: parser front end
// Takes one byte per transaction, runs the string parse state machine and
// builds the group of results that the byte causes.
// ---------------------------------------------------------------------------
module jsu8_front
	import jsu8_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       accept,
	input  wire logic [7:0] data_byte,
	input  wire logic       first_byte,
	output logic            push,
	output group_t          grp
);

	mode_t       mode_q, mode_d;
	logic [7:0]  held_q [3];
	logic [7:0]  held_d [3];
	logic [1:0]  need_q, need_d;
	logic [15:0] hex_q, hex_d;
	logic [9:0]  high_q, high_d;
	logic [1:0]  dcnt_q, dcnt_d;
	logic        fail_v;

	logic [4:0]  hex_v;
	logic        hex_ok;
	logic [15:0] acc_nxt;
	logic        acc_high, acc_low;
	logic [8:0]  esc_v;
	logic        body_lead;
	logic [20:0] pair_cp;
	logic [10:0] pair_top;
	logic [2:0]  seq_len;
	logic [1:0]  idx;
	logic [7:0]  cont_lo, cont_hi;
	logic        cont_ok;

	// Shared decode of the incoming byte
	assign hex_v     = hex_nibble(data_byte);
	assign hex_ok    = !hex_v[4];
	assign acc_nxt   = {hex_q[11:0], hex_v[3:0]};
	assign acc_high  = (acc_nxt[15:10] == SURR_HIGH);
	assign acc_low   = (acc_nxt[15:10] == SURR_LOW);
	assign esc_v     = esc_value(data_byte);
	assign body_lead = data_byte inside {[LEAD_MIN:LEAD_MAX]};
	assign pair_top  = {1'b0, high_q} + PLANE_BASE;
	assign pair_cp   = {pair_top, acc_nxt[9:0]};

	// Allowed window for the next continuation byte
	always_comb begin
		if (held_q[0] >= LEAD_4) seq_len = 3'd4;
		else if (held_q[0] >= LEAD_3) seq_len = 3'd3;
		else seq_len = 3'd2;
		idx = 2'(seq_len - {1'b0, need_q});
		if (idx == 2'd0) idx = 2'd1;
		cont_lo = CONT_MIN;
		cont_hi = CONT_MAX;
		if (idx == 2'd1) begin
			case (held_q[0])
				LEAD_3:   cont_lo = 8'hA0;
				LEAD_ED:  cont_hi = 8'h9F;
				LEAD_4:   cont_lo = 8'h90;
				LEAD_MAX: cont_hi = 8'h8F;
				default:  ;
			endcase
		end
		cont_ok = (data_byte >= cont_lo) && (data_byte <= cont_hi);
	end

	// Next state
	always_comb begin
		mode_d = mode_q;
		held_d = held_q;
		need_d = need_q;
		hex_d  = hex_q;
		high_d = high_q;
		dcnt_d = dcnt_q;
		fail_v = 1'b0;
		if (first_byte) begin
			need_d = '0;
			dcnt_d = '0;
			hex_d  = '0;
			if (data_byte == CH_QUOTE) mode_d = MODE_BODY;
			else fail_v = 1'b1;
		end else begin
			case (mode_q)
				MODE_BODY: begin
					if (data_byte == CH_NUL) fail_v = 1'b1;
					else if (data_byte == CH_QUOTE) mode_d = MODE_IDLE;
					else if (data_byte < CH_SPACE) fail_v = 1'b1;
					else if (data_byte == CH_BSLASH) mode_d = MODE_ESC;
					else if (data_byte < ASCII_END) mode_d = MODE_BODY;
					else if (body_lead) begin
						held_d[0] = data_byte;
						if (data_byte >= LEAD_4) need_d = 2'd3;
						else if (data_byte >= LEAD_3) need_d = 2'd2;
						else need_d = 2'd1;
						mode_d = MODE_UTF8;
					end else fail_v = 1'b1;
				end
				MODE_UTF8: begin
					if (!cont_ok) fail_v = 1'b1;
					else if (need_q <= 2'd1) begin
						need_d = '0;
						mode_d = MODE_BODY;
					end else begin
						if (idx != 2'd3) held_d[idx] = data_byte;
						need_d = need_q - 2'd1;
					end
				end
				MODE_ESC: begin
					if (data_byte == CH_U) begin
						hex_d  = '0;
						dcnt_d = '0;
						mode_d = MODE_HEX;
					end else if (esc_v[8]) mode_d = MODE_BODY;
					else fail_v = 1'b1;
				end
				MODE_HEX: begin
					if (!hex_ok) fail_v = 1'b1;
					else begin
						hex_d = acc_nxt;
						if (dcnt_q != 2'd3) dcnt_d = dcnt_q + 2'd1;
						else begin
							dcnt_d = '0;
							if (acc_high) begin
								high_d = acc_nxt[9:0];
								mode_d = MODE_LOW_BS;
							end else if (acc_low || acc_nxt == 16'h0000) fail_v = 1'b1;
							else mode_d = MODE_BODY;
						end
					end
				end
				MODE_LOW_BS: begin
					if (data_byte == CH_BSLASH) mode_d = MODE_LOW_U;
					else fail_v = 1'b1;
				end
				MODE_LOW_U: begin
					if (data_byte == CH_U) begin
						hex_d  = '0;
						dcnt_d = '0;
						mode_d = MODE_LOW_HEX;
					end else fail_v = 1'b1;
				end
				MODE_LOW_HEX: begin
					if (!hex_ok) fail_v = 1'b1;
					else begin
						hex_d = acc_nxt;
						if (dcnt_q != 2'd3) dcnt_d = dcnt_q + 2'd1;
						else begin
							dcnt_d = '0;
							if (!acc_low) fail_v = 1'b1;
							else mode_d = MODE_BODY;
						end
					end
				end
				default: mode_d = MODE_IDLE;
			endcase
		end
		// Drop back to idle on any fault
		if (fail_v) begin
			mode_d = MODE_IDLE;
			need_d = '0;
			dcnt_d = '0;
		end
	end

	// Result group for this byte
	always_comb begin
		grp = '0;
		if (first_byte) begin
			if (mode_q != MODE_IDLE) grp = grp_put(grp, KIND_ERROR, 8'h00, ERR_UNTERMINATED);
			if (data_byte != CH_QUOTE) grp = grp_put(grp, KIND_ERROR, 8'h00, ERR_NO_QUOTE);
		end else begin
			case (mode_q)
				MODE_BODY: begin
					if (data_byte == CH_NUL)
						grp = grp_put(grp, KIND_ERROR, 8'h00, ERR_UNTERMINATED);
					else if (data_byte == CH_QUOTE)
						grp = grp_put(grp, KIND_CLOSE, 8'h00, CODE_NONE);
					else if (data_byte < CH_SPACE)
						grp = grp_put(grp, KIND_ERROR, 8'h00, ERR_CONTROL);
					else if (data_byte == CH_BSLASH || body_lead)
						grp = '0;
					else if (data_byte < ASCII_END)
						grp = grp_put(grp, KIND_BYTE, data_byte, CODE_NONE);
					else
						grp = grp_put(grp, KIND_ERROR, 8'h00, ERR_BAD_UTF8);
				end
				MODE_UTF8: begin
					if (!cont_ok) grp = grp_put(grp, KIND_ERROR, 8'h00, ERR_BAD_UTF8);
					else if (need_q <= 2'd1) begin
						grp = grp_put(grp, KIND_BYTE, held_q[0], CODE_NONE);
						if (idx >= 2'd2) grp = grp_put(grp, KIND_BYTE, held_q[1], CODE_NONE);
						if (idx == 2'd3) grp = grp_put(grp, KIND_BYTE, held_q[2], CODE_NONE);
						grp = grp_put(grp, KIND_BYTE, data_byte, CODE_NONE);
					end
				end
				MODE_ESC: begin
					if (data_byte == CH_U) grp = '0;
					else if (esc_v[8]) grp = grp_put(grp, KIND_BYTE, esc_v[7:0], CODE_NONE);
					else grp = grp_put(grp, KIND_ERROR, 8'h00, ERR_BAD_ESCAPE);
				end
				MODE_HEX: begin
					if (!hex_ok) grp = grp_put(grp, KIND_ERROR, 8'h00, ERR_BAD_HEX);
					else if (dcnt_q == 2'd3) begin
						if (acc_high) grp = '0;
						else if (acc_low) grp = grp_put(grp, KIND_ERROR, 8'h00, ERR_LONE_LOW);
						else if (acc_nxt == 16'h0000)
							grp = grp_put(grp, KIND_ERROR, 8'h00, ERR_NUL_ESCAPE);
						else grp = grp_cp(grp, {5'b0, acc_nxt});
					end
				end
				MODE_LOW_BS: begin
					if (data_byte != CH_BSLASH)
						grp = grp_put(grp, KIND_ERROR, 8'h00, ERR_UNPAIRED_HIGH);
				end
				MODE_LOW_U: begin
					if (data_byte != CH_U)
						grp = grp_put(grp, KIND_ERROR, 8'h00, ERR_UNPAIRED_HIGH);
				end
				MODE_LOW_HEX: begin
					if (!hex_ok) grp = grp_put(grp, KIND_ERROR, 8'h00, ERR_UNPAIRED_HIGH);
					else if (dcnt_q == 2'd3) begin
						if (!acc_low) grp = grp_put(grp, KIND_ERROR, 8'h00, ERR_BAD_LOW);
						else grp = grp_cp(grp, pair_cp);
					end
				end
				default: grp = '0;
			endcase
		end
	end

	// Queue a group only when the byte causes results
	assign push = accept && (grp.cnt != '0);

	// Advance parser state on each transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= MODE_IDLE;
			held_q[0] <= '0;
			held_q[1] <= '0;
			held_q[2] <= '0;
			need_q    <= '0;
			hex_q     <= '0;
			high_q    <= '0;
			dcnt_q    <= '0;
		end else if (accept) begin
			mode_q <= mode_d;
			held_q <= held_d;
			need_q <= need_d;
			hex_q  <= hex_d;
			high_q <= high_d;
			dcnt_q <= dcnt_d;
		end
	end

endmodule
`default_nettype wire

>>> hdl/jsu8_queue.sv
`default_nettype none
// ---------------------------------------------------------------------------
// jsu8_queue: result group queue
// Small FIFO of result groups between the front end and the back end.
// ---------------------------------------------------------------------------
module jsu8_queue
	import jsu8_pkg::*;
#(
	parameter int DEPTH = QUEUE_DEPTH_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  group_t    push_grp,
	input  wire logic pop,
	output group_t    head_grp,
	output q_status_t status
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	group_t             slot_q [DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0]   count_q;
	logic               do_push, do_pop;

	assign status.empty = (count_q == '0);
	assign status.full  = (count_q == CNT_W'(DEPTH));
	assign do_push      = push && !status.full;
	assign do_pop       = pop && !status.empty;
	assign head_grp     = slot_q[rd_ptr_q];

	// Store incoming group
	always_ff @(posedge clk) begin
		if (do_push) slot_q[wr_ptr_q] <= push_grp;
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			if (do_pop)
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			if (do_push && !do_pop) count_q <= count_q + CNT_W'(1);
			else if (do_pop && !do_push) count_q <= count_q - CNT_W'(1);
		end
	end

endmodule
`default_nettype wire

>>> hdl/jsu8_back.sv
`default_nettype none
// ---------------------------------------------------------------------------
// jsu8_back: result back end
// Unpacks the head group one result per cycle, while the output is not stalled,
// into a registered output stage and marks the final result of each group.
// ---------------------------------------------------------------------------
module jsu8_back
	import jsu8_pkg::*;
(
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  group_t                      head_grp,
	input  q_status_t                   q_stat,
	output logic                        pop,
	output logic                        m_axis_tvalid,
	input  wire logic                   m_axis_tready,
	output logic [OUT_TDATA_W-1:0]      m_axis_tdata,  // [7:0] out_byte, [11:8] error_code
	output logic [OUT_TUSER_W-1:0]      m_axis_tuser,  // [1:0] result_kind
	output logic                        m_axis_tlast   // last_of_run
);

	logic [RES_IDX_W-1:0] idx_q;
	logic                 tvalid_q;
	result_t              res_q;
	logic                 last_q;
	logic                 load;
	logic                 is_last;

	assign load    = !q_stat.empty && (!tvalid_q || m_axis_tready);
	assign is_last = ({1'b0, idx_q} + RES_CNT_W'(1)) == head_grp.cnt;
	assign pop     = load && is_last;

	// Hold the output stage and its valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tvalid_q <= 1'b0;
			idx_q    <= '0;
		end else begin
			if (load) begin
				tvalid_q <= 1'b1;
				idx_q    <= is_last ? '0 : idx_q + RES_IDX_W'(1);
			end else if (m_axis_tready) begin
				tvalid_q <= 1'b0;
			end
		end
	end

	// Load the next result of the head group
	always_ff @(posedge clk) begin
		if (load) begin
			res_q  <= head_grp.res[idx_q];
			last_q <= is_last;
		end
	end

	assign m_axis_tvalid = tvalid_q;
	assign m_axis_tdata  = {{(OUT_TDATA_W - 12){1'b0}}, res_q.code, res_q.data};
	assign m_axis_tuser  = res_q.kind;
	assign m_axis_tlast  = last_q;

endmodule
`default_nettype wire

>>> dv/tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb: JSON string decoder self-checking testbench
// Streams quoted JSON strings into the decoder: a directed opening, then
// mostly well-formed strings with random content, mixed with broken strings
// and stray bytes. A scoreboard keeps its own model of the parser and checks
// every decoded byte, close and error transaction in order. The run moves
// through phases of sender idling and receiver stalls, draining between them.
// ---------------------------------------------------------------------------
module tb;
	import jsu8_pkg::*;

	localparam int WATCHDOG_LIMIT = 1000;
	localparam int DRAIN_CYCLES   = 16;
	localparam int PHASE_BYTES    = 95;

	typedef struct {
		kind_t      kind;
		logic [7:0] value;
		logic [3:0] code;
		logic       last;
	} decoded_t;

	typedef struct {
		logic [7:0] data;
		logic       first;
	} in_byte_t;

	// Parser model and in-order store of the results still awaited
	class decode_scoreboard;
		mode_t      mode;
		logic [7:0] seq_held [3];
		logic [1:0] seq_left;
		logic [15:0] hex_word;
		logic [9:0] high_bits;
		logic [1:0] hex_digits;
		decoded_t   awaited_results [$];
		int         failures;

		function new();
			mode = MODE_IDLE;
			seq_held = '{default: 8'h00};
			seq_left = '0;
			hex_word = '0;
			high_bits = '0;
			hex_digits = '0;
			failures = 0;
		endfunction

		function void add_result(kind_t kind, logic [7:0] value, logic [3:0] code);
			decoded_t r;
			r.kind = kind;
			r.value = value;
			r.code = code;
			r.last = 1'b0;
			awaited_results.push_back(r);
		endfunction

		// Report an error and drop the rest of the string
		function void abort(err_t code);
			add_result(KIND_ERROR, 8'h00, code);
			mode = MODE_IDLE;
			seq_left = '0;
			hex_digits = '0;
		endfunction

		function void add_code_point(logic [20:0] cp);
			if (cp < 21'h80) begin
				add_result(KIND_BYTE, cp[7:0], CODE_NONE);
			end else if (cp < 21'h800) begin
				add_result(KIND_BYTE, 8'(8'hC0 | (cp >> 6)), CODE_NONE);
				add_result(KIND_BYTE, 8'(8'h80 | (cp & 21'h3F)), CODE_NONE);
			end else if (cp < 21'h10000) begin
				add_result(KIND_BYTE, 8'(8'hE0 | (cp >> 12)), CODE_NONE);
				add_result(KIND_BYTE, 8'(8'h80 | ((cp >> 6) & 21'h3F)), CODE_NONE);
				add_result(KIND_BYTE, 8'(8'h80 | (cp & 21'h3F)), CODE_NONE);
			end else begin
				add_result(KIND_BYTE, 8'(8'hF0 | ((cp >> 18) & 21'h7)), CODE_NONE);
				add_result(KIND_BYTE, 8'(8'h80 | ((cp >> 12) & 21'h3F)), CODE_NONE);
				add_result(KIND_BYTE, 8'(8'h80 | ((cp >> 6) & 21'h3F)), CODE_NONE);
				add_result(KIND_BYTE, 8'(8'h80 | (cp & 21'h3F)), CODE_NONE);
			end
		endfunction

		// Bit 4 set marks a byte that is no hex digit
		function logic [4:0] digit_of(logic [7:0] c);
			if (c >= 8'h30 && c <= 8'h39) return 5'(c - 8'h30);
			if (c >= 8'h61 && c <= 8'h66) return 5'(c - 8'h61 + 8'd10);
			if (c >= 8'h41 && c <= 8'h46) return 5'(c - 8'h41 + 8'd10);
			return 5'h10;
		endfunction

		function void take_body(logic [7:0] c);
			if (c == CH_NUL) begin
				abort(ERR_UNTERMINATED);
			end else if (c == CH_QUOTE) begin
				add_result(KIND_CLOSE, 8'h00, CODE_NONE);
				mode = MODE_IDLE;
			end else if (c < CH_SPACE) begin
				abort(ERR_CONTROL);
			end else if (c == CH_BSLASH) begin
				mode = MODE_ESC;
			end else if (c < ASCII_END) begin
				add_result(KIND_BYTE, c, CODE_NONE);
			end else if (c >= LEAD_MIN && c <= LEAD_MAX) begin
				seq_held[0] = c;
				seq_left = (c >= LEAD_4) ? 2'd3 : ((c >= LEAD_3) ? 2'd2 : 2'd1);
				mode = MODE_UTF8;
			end else begin
				abort(ERR_BAD_UTF8);
			end
		endfunction

		// Continuation byte of a raw sequence; release the whole sequence at its end
		function void take_seq_byte(logic [7:0] c);
			int seq_len;
			int pos;
			int i;
			logic [7:0] lo;
			logic [7:0] hi;
			seq_len = (seq_held[0] >= LEAD_4) ? 4 : ((seq_held[0] >= LEAD_3) ? 3 : 2);
			pos = (seq_len - int'(seq_left)) & 3;
			if (pos == 0) pos = 1;
			lo = CONT_MIN;
			hi = CONT_MAX;
			// the second byte narrows for overlong, surrogate and out-of-range leads
			if (pos == 1) begin
				if (seq_held[0] == LEAD_3) lo = 8'hA0;
				else if (seq_held[0] == LEAD_ED) hi = 8'h9F;
				else if (seq_held[0] == LEAD_4) lo = 8'h90;
				else if (seq_held[0] == LEAD_MAX) hi = 8'h8F;
			end
			if (c < lo || c > hi) begin
				abort(ERR_BAD_UTF8);
			end else if (seq_left <= 2'd1) begin
				for (i = 0; i < pos && i < 3; i++)
					add_result(KIND_BYTE, seq_held[i], CODE_NONE);
				add_result(KIND_BYTE, c, CODE_NONE);
				seq_left = '0;
				mode = MODE_BODY;
			end else begin
				if (pos < 3) seq_held[pos] = c;
				seq_left = seq_left - 2'd1;
			end
		endfunction

		function void take_escape(logic [7:0] c);
			logic [7:0] v;
			bit simple;
			simple = 1'b1;
			v = c;
			case (c)
				CH_QUOTE, CH_BSLASH, CH_SLASH: v = c;
				CH_B: v = 8'h08;
				CH_F: v = 8'h0C;
				CH_N: v = 8'h0A;
				CH_R: v = 8'h0D;
				CH_T: v = 8'h09;
				CH_U: begin
					simple = 1'b0;
					hex_word = '0;
					hex_digits = '0;
					mode = MODE_HEX;
				end
				default: begin
					simple = 1'b0;
					abort(ERR_BAD_ESCAPE);
				end
			endcase
			if (simple) begin
				add_result(KIND_BYTE, v, CODE_NONE);
				mode = MODE_BODY;
			end
		endfunction

		// Hex digit of a \u escape, either the first unit or the low half of a pair
		function void take_hex(logic [7:0] c, bit low_half);
			logic [4:0] d;
			d = digit_of(c);
			if (d[4]) begin
				if (low_half) abort(ERR_UNPAIRED_HIGH);
				else abort(ERR_BAD_HEX);
				return;
			end
			hex_word = {hex_word[11:0], d[3:0]};
			if (hex_digits < 2'd3) begin
				hex_digits = hex_digits + 2'd1;
				return;
			end
			hex_digits = '0;
			if (low_half) begin
				if (hex_word[15:10] != SURR_LOW) begin
					abort(ERR_BAD_LOW);
				end else begin
					add_code_point(21'h10000 + {high_bits, hex_word[9:0]});
					mode = MODE_BODY;
				end
			end else if (hex_word[15:10] == SURR_HIGH) begin
				high_bits = hex_word[9:0];
				mode = MODE_LOW_BS;
			end else if (hex_word[15:10] == SURR_LOW) begin
				abort(ERR_LONE_LOW);
			end else if (hex_word == 16'h0000) begin
				abort(ERR_NUL_ESCAPE);
			end else begin
				add_code_point({5'b0, hex_word});
				mode = MODE_BODY;
			end
		endfunction

		// Work out the results caused by one accepted input byte
		function void decode_byte(logic [7:0] c, logic first);
			int queued_before;
			queued_before = awaited_results.size();
			if (first) begin
				if (mode != MODE_IDLE) abort(ERR_UNTERMINATED);
				seq_left = '0;
				hex_digits = '0;
				hex_word = '0;
				if (c == CH_QUOTE) mode = MODE_BODY;
				else abort(ERR_NO_QUOTE);
			end else begin
				case (mode)
					MODE_BODY:    take_body(c);
					MODE_UTF8:    take_seq_byte(c);
					MODE_ESC:     take_escape(c);
					MODE_HEX:     take_hex(c, 1'b0);
					MODE_LOW_BS: begin
						if (c == CH_BSLASH) mode = MODE_LOW_U;
						else abort(ERR_UNPAIRED_HIGH);
					end
					MODE_LOW_U: begin
						if (c == CH_U) begin
							hex_word = '0;
							hex_digits = '0;
							mode = MODE_LOW_HEX;
						end else begin
							abort(ERR_UNPAIRED_HIGH);
						end
					end
					MODE_LOW_HEX: take_hex(c, 1'b1);
					default:      mode = MODE_IDLE;
				endcase
			end
			if (awaited_results.size() > queued_before)
				awaited_results[awaited_results.size() - 1].last = 1'b1;
		endfunction

		function void note_failure(string what, decoded_t want, decoded_t got);
			failures++;
			if (failures <= 10)
				$display("%0t: %s: expected kind %0d byte %02h code %0d last %0b, ",
					$time, what, want.kind, want.value, want.code, want.last,
					"got kind %0d byte %02h code %0d last %0b",
					got.kind, got.value, got.code, got.last);
		endfunction

		// Compare one output transaction with the oldest awaited result
		function void check_result(kind_t kind, logic [7:0] value, logic [3:0] code,
				logic last);
			decoded_t got;
			decoded_t want;
			got.kind = kind;
			got.value = value;
			got.code = code;
			got.last = last;
			if (awaited_results.size() == 0) begin
				want = '{KIND_BYTE, 8'h00, 4'h0, 1'b0};
				note_failure("unexpected result", want, got);
				return;
			end
			want = awaited_results.pop_front();
			if (want.kind !== got.kind || want.value !== got.value ||
					want.code !== got.code || want.last !== got.last)
				note_failure("result mismatch", want, got);
		endfunction

		function void check_leftovers();
			decoded_t none;
			none = '{KIND_BYTE, 8'h00, 4'h0, 1'b0};
			while (awaited_results.size() > 0)
				note_failure("missing result", awaited_results.pop_front(), none);
		endfunction
	endclass

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   s_axis_tvalid = 1'b0;
	logic                   s_axis_tready;
	logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;  // [7:0] data_byte
	logic                   s_axis_tuser = 1'b0;  // [0] first_byte
	logic                   m_axis_tvalid;
	logic                   m_axis_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_axis_tdata;  // [7:0] out_byte, [11:8] error_code
	logic [OUT_TUSER_W-1:0] m_axis_tuser;  // [1:0] result_kind
	logic                   m_axis_tlast;

	decode_scoreboard scoreboard;
	in_byte_t         stim [$];
	logic [7:0]       body [$];
	int               tx_idle_pct = 0;
	int               rx_stall_pct = 0;
	int               quiet_cycles = 0;

	json_string_utf8_decoder_core i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Stimulus building
	function automatic void push_item(logic [7:0] b, logic f);
		in_byte_t it;
		it.data = b;
		it.first = f;
		stim.push_back(it);
	endfunction

	// Append a \u escape with four digits of mixed case
	function automatic void add_hex4(logic [15:0] v);
		logic [3:0] nib;
		int i;
		body.push_back(CH_BSLASH);
		body.push_back(CH_U);
		for (i = 3; i >= 0; i--) begin
			nib = v[i*4 +: 4];
			if (nib < 4'd10) body.push_back(8'h30 + 8'(nib));
			else body.push_back(($urandom_range(1) ? 8'h61 : 8'h41) + 8'(nib) - 8'd10);
		end
	endfunction

	// Append a code point as a well-formed raw sequence
	function automatic void add_utf8(logic [20:0] cp);
		if (cp < 21'h800) begin
			body.push_back(8'(8'hC0 | (cp >> 6)));
		end else if (cp < 21'h10000) begin
			body.push_back(8'(8'hE0 | (cp >> 12)));
			body.push_back(8'(8'h80 | ((cp >> 6) & 21'h3F)));
		end else begin
			body.push_back(8'(8'hF0 | (cp >> 18)));
			body.push_back(8'(8'h80 | ((cp >> 12) & 21'h3F)));
			body.push_back(8'(8'h80 | ((cp >> 6) & 21'h3F)));
		end
		if (cp >= 21'h800) body.push_back(8'(8'h80 | (cp & 21'h3F)));
		else body.push_back(8'(8'h80 | (cp & 21'h3F)));
	endfunction

	function automatic logic [15:0] bmp_value();
		case ($urandom_range(3))
			0:       return 16'($urandom_range(1, 16'h7F));
			1:       return 16'($urandom_range(16'h80, 16'h7FF));
			2:       return 16'($urandom_range(16'h800, 16'hD7FF));
			default: return 16'($urandom_range(16'hE000, 16'hFFFF));
		endcase
	endfunction

	// Raw code points, with the range limits of each length weighted up
	function automatic logic [20:0] raw_code_point();
		logic [20:0] limits [13] = '{21'h80, 21'h7FF, 21'h800, 21'hFFF, 21'hD7FF, 21'hE000,
			21'hFFFF, 21'h10000, 21'h3FFFF, 21'h40000, 21'hFFFFF, 21'h100000, 21'h10FFFF};
		if ($urandom_range(3) == 0) return limits[$urandom_range(12)];
		case ($urandom_range(3))
			0:       return 21'($urandom_range(21'h80, 21'h7FF));
			1:       return 21'($urandom_range(21'h800, 21'hD7FF));
			2:       return 21'($urandom_range(21'hE000, 21'hFFFF));
			default: return 21'($urandom_range(21'h10000, 21'h10FFFF));
		endcase
	endfunction

	// One piece of string content; rough pieces may be malformed
	function automatic void add_token(bit rough);
		logic [7:0] c;
		logic [7:0] escapes [8] = '{CH_QUOTE, CH_BSLASH, CH_SLASH, CH_B, CH_F, CH_N, CH_R, CH_T};
		case ($urandom_range(rough ? 9 : 6))
			0, 1: begin
				do c = 8'($urandom_range(8'h20, 8'h7F));
				while (c == CH_QUOTE || c == CH_BSLASH);
				body.push_back(c);
			end
			2: begin
				body.push_back(CH_BSLASH);
				body.push_back(escapes[$urandom_range(7)]);
			end
			3: add_hex4(bmp_value());
			4: begin
				add_hex4(16'hD800 | 16'($urandom_range(10'h3FF)));
				add_hex4(16'hDC00 | 16'($urandom_range(10'h3FF)));
			end
			5, 6: add_utf8(raw_code_point());
			// single \u unit: NUL and lone low halves weighted up
			7: begin
				case ($urandom_range(2))
					0:       add_hex4(16'h0000);
					1:       add_hex4(16'hDC00 | 16'($urandom_range(10'h3FF)));
					default: add_hex4(16'($urandom));
				endcase
			end
			// high half followed by something that is rarely a valid low half
			8: begin
				add_hex4(16'hD800 | 16'($urandom_range(10'h3FF)));
				case ($urandom_range(2))
					0: add_hex4(16'($urandom));
					1: body.push_back(8'($urandom));
					default: begin
						body.push_back(CH_BSLASH);
						body.push_back(8'($urandom));
					end
				endcase
			end
			default: begin
				body.push_back(8'($urandom));
				if ($urandom_range(1)) body.push_back(8'($urandom));
			end
		endcase
	endfunction

	// Queue one string; returns the bytes that count toward the phase
	function automatic int queue_string(bit rough);
		int pos;
		int count;
		body.delete();
		repeat ($urandom_range(1, 8)) add_token(rough);
		if (rough && $urandom_range(1)) begin
			pos = $urandom_range(body.size() - 1);
			body[pos] = 8'($urandom);
		end
		if (rough && $urandom_range(7) == 0) push_item(8'($urandom), 1'b1);
		else push_item(CH_QUOTE, 1'b1);
		foreach (body[i]) push_item(body[i], 1'b0);
		count = body.size() + 1;
		// rough strings are sometimes left open for the next opening byte
		if (!rough || $urandom_range(5) != 0) begin
			push_item(CH_QUOTE, 1'b0);
			count++;
		end
		// stray bytes between strings
		if ($urandom_range(5) == 0)
			repeat ($urandom_range(1, 3)) push_item(8'($urandom), 1'b0);
		return count;
	endfunction

	// Drive one input transaction, idling at random first
	task automatic send_byte(in_byte_t it);
		while ($urandom_range(99) < tx_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= it.data;
		s_axis_tuser <= it.first;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		scoreboard.decode_byte(it.data, it.first);
	endtask

	task automatic drive_queued();
		while (stim.size() > 0) send_byte(stim.pop_front());
		s_axis_tvalid <= 1'b0;
	endtask

	// Hold the sender until every result has come
	task automatic wait_drained();
		do @(posedge clk);
		while (scoreboard.awaited_results.size() != 0);
	endtask

	// Receive side: check each output transaction, then stall at random
	always @(posedge clk) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else begin
			if (m_axis_tvalid && m_axis_tready)
				scoreboard.check_result(kind_t'(m_axis_tuser), m_axis_tdata[7:0],
					m_axis_tdata[11:8], m_axis_tlast);
			m_axis_tready <= ($urandom_range(99) >= rx_stall_pct);
		end
	end

	// Watchdog: count cycles with no transaction on either side
	always @(posedge clk) begin
		if (!arst_n || (s_axis_tvalid && s_axis_tready) ||
				(m_axis_tvalid && m_axis_tready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles < WATCHDOG_LIMIT) begin
			quiet_cycles <= quiet_cycles + 1;
		end else begin
			$display("Verification failed");
			$finish;
		end
	end

	initial begin
		int tx_pct [4];
		int rx_pct [4];
		int queued;
		int p;
		tx_pct = '{0, 65, 0, 27};
		rx_pct = '{0, 0, 65, 27};
		scoreboard = new();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// stray byte with no string open, then an opening byte that is not a quote
		push_item(8'hFF, 1'b0);
		push_item(CH_NUL, 1'b1);
		// largest raw code point, a simple escape, a proper close
		push_item(CH_QUOTE, 1'b1);
		push_item(8'hF4, 1'b0);
		push_item(8'h8F, 1'b0);
		push_item(8'hBF, 1'b0);
		push_item(8'hBF, 1'b0);
		push_item(CH_BSLASH, 1'b0);
		push_item(CH_T, 1'b0);
		push_item(CH_QUOTE, 1'b0);
		// NUL after a backslash
		push_item(CH_QUOTE, 1'b1);
		push_item(CH_BSLASH, 1'b0);
		push_item(CH_NUL, 1'b0);
		// bad lead byte
		push_item(CH_QUOTE, 1'b1);
		push_item(8'hC1, 1'b0);
		// surrogate encoded raw: bad continuation
		push_item(CH_QUOTE, 1'b1);
		push_item(8'hED, 1'b0);
		push_item(8'hA0, 1'b0);
		// restart of an open string, then NUL among the hex digits
		push_item(CH_QUOTE, 1'b1);
		push_item(8'h41, 1'b0);
		push_item(CH_QUOTE, 1'b1);
		push_item(CH_BSLASH, 1'b0);
		push_item(CH_U, 1'b0);
		push_item(8'h30, 1'b0);
		push_item(CH_NUL, 1'b0);
		// high half followed by a plain byte
		push_item(CH_QUOTE, 1'b1);
		push_item(CH_BSLASH, 1'b0);
		push_item(CH_U, 1'b0);
		push_item(8'h44, 1'b0);
		push_item(8'h38, 1'b0);
		push_item(8'h30, 1'b0);
		push_item(8'h30, 1'b0);
		push_item(8'h78, 1'b0);

		// random phases; hold the sender until the results drain between them
		for (p = 0; p < 4; p++) begin
			tx_idle_pct = tx_pct[p];
			rx_stall_pct = rx_pct[p];
			queued = 0;
			while (queued < PHASE_BYTES) queued += queue_string($urandom_range(3) == 0);
			drive_queued();
			wait_drained();
		end

		repeat (DRAIN_CYCLES) @(posedge clk);
		scoreboard.check_leftovers();
		if (scoreboard.failures == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
